@@ sv/lrp_pkg.sv @@
`timescale 1ns / 1ps

package lrp_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_CLASSES = 8;
	localparam int NCOL        = MAX_CLASSES - 1;
	localparam int COL_W       = 3;
	localparam int CLS_W       = 3;
	localparam int CNT_W       = 4;
	localparam int VPC_W       = 11;
	localparam int MODE_W      = 3;
	localparam int FIDX_W      = 10;
	localparam int DATA_W      = 32;

	localparam int ACC_W  = 48;
	localparam int MUL_W  = 36;
	localparam int PROD_W = 2 * MUL_W;
	localparam int P_W    = FRAC_BITS + 1;
	localparam int E_W    = 31;
	localparam int DEN_W  = 34;
	localparam int NUM_W  = 48;
	localparam int A_W    = 36;
	localparam int RCP_W  = 35;
	localparam int SUM_W  = 20;

	localparam logic [P_W-1:0]   FX_ONE    = P_W'(1) << FRAC_BITS;
	localparam logic [A_W-1:0]   LN2_Q30   = A_W'(744261118);
	localparam logic [ACC_W:0]   EXP_LIMIT = (ACC_W + 1)'(40) << FRAC_BITS;
	localparam logic [E_W-1:0]   Q30_ONE   = E_W'(1) << 30;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VARS_PER_CLASS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_MARGIN = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PROB   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PVEC   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RANK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLASS  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_MAXP   = 3'd5;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_FEATURE = 1'b1;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// ceil(2^34 / n) for the Taylor term divisors
	function automatic logic [RCP_W-1:0] recip(input logic [3:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			4'd1:    r = 35'd17179869184;
			4'd2:    r = 35'd8589934592;
			4'd3:    r = 35'd5726623062;
			4'd4:    r = 35'd4294967296;
			4'd5:    r = 35'd3435973837;
			4'd6:    r = 35'd2863311531;
			4'd7:    r = 35'd2454267027;
			4'd8:    r = 35'd2147483648;
			4'd9:    r = 35'd1908874354;
			4'd10:   r = 35'd1717986919;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/logistic_regression_predictor_top.sv @@
`timescale 1ns / 1ps

// Logistic regression predictor. A coefficient write (operation 0) leaves
// busy low. For a feature item whose index is below vars_per_class and
// MAX_VARS, the seven coefficient columns are read one per cycle from the
// coefficient RAM and go through one shared multiplier into the saturating
// margin accumulators. An item with last_feature then starts the margin
// scan; in probability modes each class takes an exponential on the same
// multiplier (6 range-reduction steps, up to 10 Taylor terms, each a
// multiply, a multiply by 1/n and an accumulate) and each non-reference
// class a division in the bit-serial divider, plus the max-probability
// scan in max-probability mode. Results leave one per cycle on result_strobe
// and the receiver cannot stall them; start is taken only while busy is low.

module logistic_regression_predictor_top #(
	parameter int MAX_VARS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [lrp_pkg::COL_W-1:0]           column,
	input  logic [lrp_pkg::FIDX_W-1:0]          feature_index,
	input  logic signed [lrp_pkg::DATA_W-1:0]   value,
	input  logic                                last_feature,
	input  logic                                cfg_write,
	input  logic [lrp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lrp_pkg::VPC_W-1:0]           cfg_data,
	output logic                                result_strobe,
	output logic [lrp_pkg::CLS_W-1:0]           class_slot,
	output logic signed [lrp_pkg::DATA_W-1:0]   result_value,
	output logic                                unsupported,
	output logic                                last_result
);

	localparam int DEPTH = lrp_pkg::NCOL * MAX_VARS;
	localparam int AW    = $clog2(DEPTH);
	localparam int ACC_W = lrp_pkg::ACC_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FEAT = 4'd1;
	localparam logic [3:0] S_MAX  = 4'd2;
	localparam logic [3:0] S_EXPA = 4'd3;
	localparam logic [3:0] S_EXPK = 4'd4;
	localparam logic [3:0] S_TMUL = 4'd5;
	localparam logic [3:0] S_TDIV = 4'd6;
	localparam logic [3:0] S_TACC = 4'd7;
	localparam logic [3:0] S_EFIN = 4'd8;
	localparam logic [3:0] S_DIVS = 4'd9;
	localparam logic [3:0] S_DIVW = 4'd10;
	localparam logic [3:0] S_P0   = 4'd11;
	localparam logic [3:0] S_ARGP = 4'd12;
	localparam logic [3:0] S_EMIT = 4'd13;

	logic [3:0] state_q;

	logic [lrp_pkg::CNT_W-1:0]  class_count_q;
	logic [lrp_pkg::VPC_W-1:0]  vars_per_class_q;
	logic [lrp_pkg::MODE_W-1:0] output_mode_q;

	logic signed [lrp_pkg::DATA_W-1:0] x_q;
	logic [lrp_pkg::FIDX_W-1:0]        fidx_q;
	logic                              last_q;

	logic [lrp_pkg::COL_W-1:0] rd_col_q;
	logic                      v_s1, v_s2;
	logic [lrp_pkg::COL_W-1:0] col_s1, col_s2;

	logic signed [ACC_W-1:0] acc_q [lrp_pkg::NCOL];
	logic signed [ACC_W-1:0] mx_q;
	logic [lrp_pkg::CLS_W-1:0] idx_q, bestm_q, bestp_q;

	logic [lrp_pkg::A_W-1:0]  a_q;
	logic [5:0]               k_q;
	logic [2:0]               kbit_q;
	logic                     zero_q;
	logic [lrp_pkg::E_W-1:0]  term_q;
	logic signed [31:0]       sum_q;
	logic [3:0]               tn_q;
	logic [lrp_pkg::E_W-1:0]  e_q [lrp_pkg::MAX_CLASSES];
	logic [lrp_pkg::DEN_W-1:0] den_q;
	logic [lrp_pkg::P_W-1:0]  p_q [lrp_pkg::MAX_CLASSES];
	logic [lrp_pkg::SUM_W-1:0] s_q;
	logic [lrp_pkg::P_W-1:0]  bp_q;

	logic                     accept;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [lrp_pkg::DATA_W-1:0] ram_rdata;
	logic                     rd_act;
	logic                     idx_ok;

	logic signed [lrp_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [lrp_pkg::PROD_W-1:0] prod_q;

	lrp_pkg::div_req_t        div_req;
	logic                     div_done;
	logic [lrp_pkg::P_W-1:0]  div_quo;

	logic [lrp_pkg::CNT_W-1:0] n_cls;
	logic [lrp_pkg::CLS_W-1:0] nm1;
	logic                      bin, idx_last, unsup, needs_p, prob_val;
	logic [lrp_pkg::CLS_W-1:0] acc_ri;
	logic signed [ACC_W-1:0]   acc_rd, mi, pv;
	logic signed [ACC_W:0]     acc_sum, diff;
	logic signed [ACC_W-1:0]   acc_sat;
	logic                      exp_far;
	logic [lrp_pkg::A_W-1:0]   a_init, ln2_sh;
	logic                      k_hit;
	logic [5:0]                k_nx;
	logic [lrp_pkg::E_W-1:0]   ev;
	logic [lrp_pkg::P_W-1:0]   p_new, p0;
	logic [lrp_pkg::CLS_W-1:0] eb, ee;
	logic [lrp_pkg::CLS_W-1:0] o_slot;
	logic signed [lrp_pkg::DATA_W-1:0] o_val, mi_sat;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign idx_ok = 32'(feature_index) < MAX_VARS;
	assign ram_we = accept && operation == lrp_pkg::OP_WRITE &&
		32'(column) < lrp_pkg::NCOL && idx_ok;
	assign ram_waddr = AW'(32'(column) * MAX_VARS + 32'(feature_index));
	assign ram_raddr = AW'(32'(rd_col_q) * MAX_VARS + 32'(fidx_q));
	assign rd_act    = state_q == S_FEAT && 32'(rd_col_q) != lrp_pkg::NCOL;

	lrp_ram #(
		.WIDTH(lrp_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		case (state_q)
			S_FEAT: begin
				mul_a = lrp_pkg::MUL_W'(signed'(ram_rdata));
				mul_b = lrp_pkg::MUL_W'(x_q);
			end
			S_TDIV: begin
				mul_a = lrp_pkg::MUL_W'(prod_q[59:30]);
				mul_b = lrp_pkg::MUL_W'(lrp_pkg::recip(tn_q));
			end
			default: begin
				mul_a = lrp_pkg::MUL_W'(term_q);
				mul_b = lrp_pkg::MUL_W'(a_q[29:0]);
			end
		endcase
	end

	lrp_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_comb begin
		div_req.start = state_q == S_DIVS;
		div_req.num   = lrp_pkg::NUM_W'({e_q[idx_q], lrp_pkg::FRAC_BITS'(0)}) +
			lrp_pkg::NUM_W'(den_q >> 1);
		div_req.den   = den_q;
	end

	lrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done_q (div_done),
		.quo_q  (div_quo)
	);

	always_comb begin
		if (class_count_q < 4'd2) begin
			n_cls = 4'd2;
		end else if (32'(class_count_q) > lrp_pkg::MAX_CLASSES) begin
			n_cls = lrp_pkg::CNT_W'(lrp_pkg::MAX_CLASSES);
		end else begin
			n_cls = class_count_q;
		end
		nm1      = lrp_pkg::CLS_W'(n_cls - 4'd1);
		bin      = n_cls == 4'd2;
		idx_last = idx_q == nm1;
		unsup    = output_mode_q > lrp_pkg::MODE_MAXP ||
			(bin && output_mode_q == lrp_pkg::MODE_MAXP);
		prob_val = output_mode_q == lrp_pkg::MODE_PROB ||
			output_mode_q == lrp_pkg::MODE_PVEC ||
			(bin && output_mode_q == lrp_pkg::MODE_RANK);
		needs_p  = !unsup && (prob_val || output_mode_q == lrp_pkg::MODE_MAXP);

		acc_ri = (state_q == S_FEAT) ? col_s2 : idx_q - 1'b1;
		acc_rd = (32'(acc_ri) < lrp_pkg::NCOL) ? acc_q[acc_ri] : '0;
		mi     = (idx_q == '0) ? '0 : acc_rd;

		pv      = prod_q[lrp_pkg::FRAC_BITS +: ACC_W];
		acc_sum = {acc_rd[ACC_W-1], acc_rd} + {pv[ACC_W-1], pv};
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end

		diff    = {mx_q[ACC_W-1], mx_q} - {mi[ACC_W-1], mi};
		exp_far = diff > signed'(lrp_pkg::EXP_LIMIT);
		a_init  = lrp_pkg::A_W'(diff) << (30 - lrp_pkg::FRAC_BITS);
		ln2_sh  = lrp_pkg::LN2_Q30 << kbit_q;
		k_hit   = a_q >= ln2_sh;
		k_nx    = k_q | (6'(k_hit) << kbit_q);
		ev      = (zero_q || sum_q[31]) ? '0 : lrp_pkg::E_W'(sum_q[30:0] >> k_q);

		p_new = (div_quo > lrp_pkg::FX_ONE) ? lrp_pkg::FX_ONE : div_quo;
		p0    = (s_q >= lrp_pkg::SUM_W'(lrp_pkg::FX_ONE)) ? '0 :
			lrp_pkg::P_W'(lrp_pkg::SUM_W'(lrp_pkg::FX_ONE) - s_q);

		if (unsup || output_mode_q == lrp_pkg::MODE_CLASS ||
			output_mode_q == lrp_pkg::MODE_MAXP) begin
			eb = bin ? 3'd1 : 3'd0;
			ee = eb;
		end else if (bin && output_mode_q != lrp_pkg::MODE_PVEC) begin
			eb = 3'd1;
			ee = 3'd1;
		end else begin
			eb = 3'd0;
			ee = nm1;
		end

		if (!(&mi[ACC_W-1:31] || ~|mi[ACC_W-1:31])) begin
			mi_sat = mi[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			mi_sat = mi[31:0];
		end

		if (unsup) begin
			o_slot = '0;
			o_val  = '0;
		end else if (output_mode_q == lrp_pkg::MODE_CLASS) begin
			o_slot = bin ? lrp_pkg::CLS_W'(!mi[ACC_W-1]) : bestm_q;
			o_val  = '0;
		end else if (output_mode_q == lrp_pkg::MODE_MAXP) begin
			o_slot = bestp_q;
			o_val  = lrp_pkg::DATA_W'(bp_q);
		end else if (prob_val) begin
			o_slot = idx_q;
			o_val  = lrp_pkg::DATA_W'(p_q[idx_q]);
		end else begin
			o_slot = idx_q;
			o_val  = mi_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			class_count_q    <= 4'd2;
			vars_per_class_q <= 11'd1;
			output_mode_q    <= lrp_pkg::MODE_MARGIN;
			v_s1             <= 1'b0;
			v_s2             <= 1'b0;
			result_strobe    <= 1'b0;
			for (int c = 0; c < lrp_pkg::NCOL; c++) begin
				acc_q[c] <= '0;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					lrp_pkg::REG_CLASS_COUNT:    class_count_q    <= cfg_data[lrp_pkg::CNT_W-1:0];
					lrp_pkg::REG_VARS_PER_CLASS: vars_per_class_q <= cfg_data;
					lrp_pkg::REG_OUTPUT_MODE:    output_mode_q    <= cfg_data[lrp_pkg::MODE_W-1:0];
					default: ;
				endcase
			end

			v_s1          <= rd_act;
			v_s2          <= v_s1;
			result_strobe <= state_q == S_EMIT;

			case (state_q)
				S_IDLE: begin
					if (accept && operation == lrp_pkg::OP_FEATURE) begin
						if (idx_ok && 11'(feature_index) < vars_per_class_q) begin
							state_q <= S_FEAT;
						end else if (last_feature) begin
							state_q <= S_MAX;
						end
					end
				end
				S_FEAT: begin
					if (v_s2) begin
						acc_q[col_s2] <= acc_sat;
						if (32'(col_s2) == lrp_pkg::NCOL - 1) begin
							state_q <= last_q ? S_MAX : S_IDLE;
						end
					end
				end
				S_MAX: begin
					if (idx_last) begin
						state_q <= needs_p ? S_EXPA : S_EMIT;
					end
				end
				S_EXPA: state_q <= exp_far ? S_EFIN : S_EXPK;
				S_EXPK: begin
					if (kbit_q == '0) begin
						state_q <= (k_nx >= 6'd31) ? S_EFIN : S_TMUL;
					end
				end
				S_TMUL: state_q <= S_TDIV;
				S_TDIV: state_q <= S_TACC;
				S_TACC: state_q <= (tn_q == 4'd10) ? S_EFIN : S_TMUL;
				S_EFIN: state_q <= idx_last ? S_DIVS : S_EXPA;
				S_DIVS: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						state_q <= idx_last ? S_P0 : S_DIVS;
					end
				end
				S_P0: begin
					state_q <= (output_mode_q == lrp_pkg::MODE_MAXP) ? S_ARGP : S_EMIT;
				end
				S_ARGP: begin
					if (idx_last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (idx_q == ee) begin
						state_q <= S_IDLE;
						for (int c = 0; c < lrp_pkg::NCOL; c++) begin
							acc_q[c] <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= rd_col_q;
		col_s2 <= col_s1;
		if (state_q == S_EMIT) begin
			class_slot   <= o_slot;
			result_value <= o_val;
			unsupported  <= unsup;
			last_result  <= idx_q == ee;
		end

		case (state_q)
			S_IDLE: begin
				x_q      <= value;
				fidx_q   <= feature_index;
				last_q   <= last_feature;
				rd_col_q <= '0;
				idx_q    <= 3'd1;
				mx_q     <= '0;
				bestm_q  <= '0;
			end
			S_FEAT: begin
				if (rd_act) begin
					rd_col_q <= rd_col_q + 1'b1;
				end
			end
			S_MAX: begin
				if (mi > mx_q) begin
					mx_q    <= mi;
					bestm_q <= idx_q;
				end
				idx_q <= idx_last ? (needs_p ? 3'd0 : eb) : idx_q + 1'b1;
				den_q <= '0;
			end
			S_EXPA: begin
				zero_q <= exp_far;
				a_q    <= a_init;
				k_q    <= '0;
				kbit_q <= 3'd5;
			end
			S_EXPK: begin
				if (k_hit) begin
					a_q <= a_q - ln2_sh;
				end
				k_q    <= k_nx;
				kbit_q <= kbit_q - 1'b1;
				zero_q <= k_nx >= 6'd31;
				term_q <= lrp_pkg::Q30_ONE;
				sum_q  <= 32'(lrp_pkg::Q30_ONE);
				tn_q   <= 4'd1;
			end
			S_TACC: begin
				term_q <= lrp_pkg::E_W'(prod_q[63:34]);
				if (tn_q[0]) begin
					sum_q <= sum_q - 32'(prod_q[63:34]);
				end else begin
					sum_q <= sum_q + 32'(prod_q[63:34]);
				end
				tn_q <= tn_q + 1'b1;
			end
			S_EFIN: begin
				e_q[idx_q] <= ev;
				den_q      <= den_q + lrp_pkg::DEN_W'(ev);
				idx_q      <= idx_last ? 3'd1 : idx_q + 1'b1;
				s_q        <= '0;
			end
			S_DIVW: begin
				if (div_done) begin
					p_q[idx_q] <= p_new;
					s_q        <= s_q + lrp_pkg::SUM_W'(p_new);
					if (!idx_last) begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			S_P0: begin
				p_q[0]  <= p0;
				bp_q    <= p0;
				bestp_q <= '0;
				idx_q   <= (output_mode_q == lrp_pkg::MODE_MAXP) ? 3'd1 : eb;
			end
			S_ARGP: begin
				if (p_q[idx_q] > bp_q) begin
					bp_q    <= p_q[idx_q];
					bestp_q <= idx_q;
				end
				idx_q <= idx_last ? eb : idx_q + 1'b1;
			end
			S_EMIT: begin
				idx_q <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/lrp_ram.sv @@
`timescale 1ns / 1ps

module lrp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 7168
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/lrp_mul.sv @@
`timescale 1ns / 1ps

module lrp_mul (
	input  logic                                clk,
	input  logic signed [lrp_pkg::MUL_W-1:0]    a,
	input  logic signed [lrp_pkg::MUL_W-1:0]    b,
	output logic signed [lrp_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

@@ sv/lrp_div.sv @@
`timescale 1ns / 1ps

module lrp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lrp_pkg::div_req_t          req,
	output logic                       done_q,
	output logic [lrp_pkg::P_W-1:0]    quo_q
);

	localparam int SH_W  = lrp_pkg::DEN_W + lrp_pkg::P_W - 1;
	localparam int CMP_W = (SH_W > lrp_pkg::NUM_W) ? SH_W : lrp_pkg::NUM_W;
	localparam int BIT_W = $clog2(lrp_pkg::P_W);

	logic [lrp_pkg::NUM_W-1:0] rem_q;
	logic [lrp_pkg::DEN_W-1:0] den_q;
	logic [BIT_W-1:0]          bit_q;
	logic                      run_q;
	logic [CMP_W-1:0]          den_sh;
	logic [CMP_W-1:0]          rem_ext;
	logic                      fits;

	always_comb begin
		den_sh  = CMP_W'(den_q) << bit_q;
		rem_ext = CMP_W'(rem_q);
		fits    = rem_ext >= den_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			if (bit_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			bit_q <= BIT_W'(lrp_pkg::P_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q        <= lrp_pkg::NUM_W'(rem_ext - den_sh);
				quo_q[bit_q] <= 1'b1;
			end
			if (bit_q != '0) begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/lrp_checker.sv @@
`timescale 1ns / 1ps

module lrp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              operation,
	input logic                              result_strobe,
	input logic [lrp_pkg::CLS_W-1:0]         class_slot,
	input logic signed [lrp_pkg::DATA_W-1:0] result_value,
	input logic                              unsupported,
	input logic                              last_result
);

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_result |=> !result_strobe)
		else $error("result right after final result");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_result |=> result_strobe)
		else $error("result burst broken");

	a_busy_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_result |-> busy)
		else $error("idle in the middle of a result burst");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == lrp_pkg::OP_WRITE |=> !busy)
		else $error("coefficient write made the block busy");

	a_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && unsupported |-> last_result && class_slot == '0 &&
			result_value == '0)
		else $error("malformed error result");

endmodule

bind logistic_regression_predictor_top lrp_checker u_lrp_checker (.*);
